### design/st13_pkg.sv
// shared constants, types and a helper function for the 13-point stencil filter
// no dependencies
package st13_pkg;

  localparam int unsigned SIZE_X = 16;
  localparam int unsigned SIZE_Y = 16;
  localparam int unsigned SIZE_Z = 16;

  localparam int unsigned ROW_LEN   = SIZE_Y;
  localparam int unsigned PLANE_LEN = SIZE_X * SIZE_Y;
  localparam int unsigned VOL_LEN   = PLANE_LEN * SIZE_Z;
  localparam int unsigned LAG       = PLANE_LEN + ROW_LEN + 1;

  localparam int unsigned CNT_W = $clog2(VOL_LEN + 1);
  localparam int unsigned X_W   = $clog2(SIZE_X);
  localparam int unsigned Y_W   = $clog2(SIZE_Y);
  localparam int unsigned Z_W   = $clog2(SIZE_Z);

  // delay lengths inside one plane cell
  localparam int unsigned DLY_ROW   = ROW_LEN;
  localparam int unsigned DLY_ROWM1 = ROW_LEN - 1;
  localparam int unsigned DLY_NEXT  = PLANE_LEN - ROW_LEN - 2;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned PSUM_W    = DATA_W + 2;
  localparam int unsigned DIV_W     = 40;
  localparam int unsigned DIGIT_W   = 8;
  localparam int unsigned DIV_STEPS = DIV_W / DIGIT_W;
  localparam int unsigned REM_W     = 4;
  localparam int unsigned DIVISOR   = 13;
  localparam int unsigned CTR_WEIGHT_SH_HI = 3;  // 12 = 8 + 4
  localparam int unsigned CTR_WEIGHT_SH_LO = 2;

  // bias of 13 * 2^32 keeps the dividend positive, quotient low word is unchanged
  localparam logic [DIV_W-1:0] DIV_BIAS = DIV_W'(DIVISOR) << DATA_W;

  localparam int unsigned OUT_DEPTH = 16;
  localparam int unsigned OUT_AW    = $clog2(OUT_DEPTH);
  localparam int unsigned OPTR_W    = OUT_AW + 1;
  localparam int unsigned OCNT_W    = $clog2(OUT_DEPTH + 1);

  localparam int unsigned NUM_PLANES = 3;
  localparam int unsigned MID_PLANE  = 1;

  typedef struct packed {
    logic [DATA_W-1:0] up;   // (x+1, y+1)
    logic [DATA_W-1:0] p1;   // (x, y+1)
    logic [DATA_W-1:0] ctr;  // (x, y)
    logic [DATA_W-1:0] m1;   // (x, y-1)
    logic [DATA_W-1:0] dn;   // (x-1, y-1)
  } tap_t;

  typedef struct packed {
    logic valid;
    logic bypass;
    logic last;
  } meta_t;

  typedef struct packed {
    logic              valid;
    logic              last;
    logic [DATA_W-1:0] value;
  } res_t;

  // one radix-256 digit of long division by 13
  function automatic logic [REM_W+DIGIT_W-1:0] div13_digit(input logic [REM_W-1:0] rem_in,
                                                           input logic [DIGIT_W-1:0] din);
    logic [REM_W:0]     t;
    logic [REM_W-1:0]   r;
    logic [DIGIT_W-1:0] q;
    r = rem_in;
    q = '0;
    for (int i = DIGIT_W - 1; i >= 0; i--) begin
      t = {r, din[i]};
      if (t >= (REM_W+1)'(DIVISOR)) begin
        q[i] = 1'b1;
        r    = REM_W'(t - (REM_W+1)'(DIVISOR));
      end else begin
        r = t[REM_W-1:0];
      end
    end
    return {r, q};
  endfunction

endpackage

### design/st13_dly_ram.sv
// fixed-length delay line built on a single-port circular memory
// depends on nothing; depth and width set per instance
module st13_dly_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [WIDTH-1:0] din_i,
  output logic [WIDTH-1:0] dout_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    ptr_q, ptr_d;
  logic [WIDTH-1:0] dout_q;

  always_comb begin
    if (ptr_q == AW'(DEPTH - 1)) begin
      ptr_d = '0;
    end else begin
      ptr_d = ptr_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
    end else if (en_i) begin
      ptr_q <= ptr_d;
    end
  end

  // read before write: the old word left DEPTH advances ago
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dout_q      <= mem[ptr_q];
      mem[ptr_q]  <= din_i;
    end
  end

  assign dout_o = dout_q;

endmodule

### design/st13_cell.sv
// one plane cell: row delays and tap registers for a single z plane
// depends on st13_pkg and st13_dly_ram
module st13_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        shift_i,
  input  logic [st13_pkg::DATA_W-1:0] in_i,
  output st13_pkg::tap_t              taps_o,
  output logic [st13_pkg::DATA_W-1:0] nxt_o
);

  logic [st13_pkg::DATA_W-1:0] up_q;
  logic [st13_pkg::DATA_W-1:0] p1_w;
  logic [st13_pkg::DATA_W-1:0] ctr_q;
  logic [st13_pkg::DATA_W-1:0] m1_q;
  logic [st13_pkg::DATA_W-1:0] dn_w;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      up_q  <= in_i;
      ctr_q <= p1_w;
      m1_q  <= ctr_q;
    end
  end

  // one row behind the incoming word
  st13_dly_ram #(
    .DEPTH (st13_pkg::DLY_ROW),
    .WIDTH (st13_pkg::DATA_W)
  ) u_row_a (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (shift_i),
    .din_i  (in_i),
    .dout_o (p1_w)
  );

  st13_dly_ram #(
    .DEPTH (st13_pkg::DLY_ROWM1),
    .WIDTH (st13_pkg::DATA_W)
  ) u_row_b (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (shift_i),
    .din_i  (m1_q),
    .dout_o (dn_w)
  );

  // rest of the plane, so the next cell sees the same word one plane later
  st13_dly_ram #(
    .DEPTH (st13_pkg::DLY_NEXT),
    .WIDTH (st13_pkg::DATA_W)
  ) u_plane (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (shift_i),
    .din_i  (p1_w),
    .dout_o (nxt_o)
  );

  assign taps_o.up  = up_q;
  assign taps_o.p1  = p1_w;
  assign taps_o.ctr = ctr_q;
  assign taps_o.m1  = m1_q;
  assign taps_o.dn  = dn_w;

endmodule

### design/st13_calc.sv
// weighted sum of the thirteen taps and pipelined floor division by 13
// depends on st13_pkg
module st13_calc (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  st13_pkg::meta_t                                meta_i,
  input  st13_pkg::tap_t [st13_pkg::NUM_PLANES-1:0]      taps_i,
  output st13_pkg::res_t                                 res_o
);

  typedef struct packed {
    logic                          last;
    logic [st13_pkg::REM_W-1:0]    rem;
    logic [st13_pkg::DIV_W-1:0]    num;
    logic [st13_pkg::DATA_W-1:0]   quo;
  } div_t;

  function automatic logic [st13_pkg::PSUM_W-1:0] sx_psum(input logic [st13_pkg::DATA_W-1:0] v);
    return {{(st13_pkg::PSUM_W - st13_pkg::DATA_W){v[st13_pkg::DATA_W-1]}}, v};
  endfunction

  function automatic logic [st13_pkg::DIV_W-1:0] sx_div(input logic [st13_pkg::PSUM_W-1:0] v);
    return {{(st13_pkg::DIV_W - st13_pkg::PSUM_W){v[st13_pkg::PSUM_W-1]}}, v};
  endfunction

  // stage 1: per-plane sums and weighted center plus bias
  logic [st13_pkg::PSUM_W-1:0] psum_q [st13_pkg::NUM_PLANES];
  logic [st13_pkg::PSUM_W-1:0] psum_d [st13_pkg::NUM_PLANES];
  logic [st13_pkg::DIV_W-1:0]  ctr_x;
  logic [st13_pkg::DIV_W-1:0]  base_d, base_q;
  logic [st13_pkg::DIV_W-1:0]  ctr_q;
  logic                        s1_vld_q, s1_byp_q, s1_last_q;

  always_comb begin
    for (int i = 0; i < st13_pkg::NUM_PLANES; i++) begin
      psum_d[i] = sx_psum(taps_i[i].up) + sx_psum(taps_i[i].p1)
                + sx_psum(taps_i[i].m1) + sx_psum(taps_i[i].dn);
    end
  end

  assign ctr_x  = sx_div(sx_psum(taps_i[st13_pkg::MID_PLANE].ctr));
  assign base_d = (ctr_x << st13_pkg::CTR_WEIGHT_SH_HI) + (ctr_x << st13_pkg::CTR_WEIGHT_SH_LO)
                + st13_pkg::DIV_BIAS;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < st13_pkg::NUM_PLANES; i++) begin
      psum_q[i] <= psum_d[i];
    end
    base_q    <= base_d;
    ctr_q     <= ctr_x;
    s1_byp_q  <= meta_i.bypass;
    s1_last_q <= meta_i.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= meta_i.valid;
    end
  end

  // stage 2: dividend; a face voxel turns into 13*c so the quotient is c itself
  logic [st13_pkg::DIV_W-1:0] nb_sum;
  div_t                       dv_q [st13_pkg::DIV_STEPS+1];
  div_t                       dv_d [st13_pkg::DIV_STEPS+1];
  logic [st13_pkg::DIV_STEPS:0] dvld_q;

  assign nb_sum = sx_div(psum_q[0]) + sx_div(psum_q[1]) + sx_div(psum_q[2]);

  always_comb begin
    dv_d[0].last = s1_last_q;
    dv_d[0].rem  = '0;
    dv_d[0].num  = base_q + (s1_byp_q ? ctr_q : nb_sum);
    dv_d[0].quo  = '0;
  end

  // stages 3 and on: one quotient digit per stage, most significant first
  for (genvar j = 0; j < st13_pkg::DIV_STEPS; j++) begin : g_div
    logic [st13_pkg::REM_W+st13_pkg::DIGIT_W-1:0] dig;
    assign dig = st13_pkg::div13_digit(dv_q[j].rem,
                   dv_q[j].num[st13_pkg::DIV_W-1 -: st13_pkg::DIGIT_W]);
    always_comb begin
      dv_d[j+1].last = dv_q[j].last;
      dv_d[j+1].rem  = dig[st13_pkg::REM_W+st13_pkg::DIGIT_W-1 -: st13_pkg::REM_W];
      dv_d[j+1].num  = dv_q[j].num << st13_pkg::DIGIT_W;
      dv_d[j+1].quo  = {dv_q[j].quo[st13_pkg::DATA_W-st13_pkg::DIGIT_W-1:0],
                        dig[st13_pkg::DIGIT_W-1:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j <= st13_pkg::DIV_STEPS; j++) begin
      dv_q[j] <= dv_d[j];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvld_q <= '0;
    end else begin
      dvld_q <= {dvld_q[st13_pkg::DIV_STEPS-1:0], s1_vld_q};
    end
  end

  assign res_o.valid = dvld_q[st13_pkg::DIV_STEPS];
  assign res_o.last  = dv_q[st13_pkg::DIV_STEPS].last;
  assign res_o.value = dv_q[st13_pkg::DIV_STEPS].quo;

endmodule

### design/stencil_3d_13pt_filter_unit.sv
// a result word passes the sum, dividend and digit stages and the output queue
// after its input word; its voxel entered one plane, one row and one sample earlier
// throughput: one word per cycle, set by the three chained plane cells and the
// sum/divide pipeline; input stalls once 16 results are in flight or queued
// reset: counters, valid bits and queue pointers clear at once, line buffers hold
// garbage until filled and unwritten words only reach face voxels, which ignore them
module stencil_3d_13pt_filter_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        mode_i,
  input  logic [st13_pkg::DATA_W-1:0] sample_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [st13_pkg::DATA_W-1:0] value_o,
  output logic                        last_o
);

  typedef struct packed {
    logic                        last;
    logic [st13_pkg::DATA_W-1:0] value;
  } oent_t;

  logic                         accept, take_smp, take_drn, shift, emit, pop;
  logic                         vol_full, bypass_w, last_w;
  logic                         x_max, y_max, z_max;
  logic [st13_pkg::CNT_W-1:0]   in_cnt_q, in_cnt_d;
  logic [st13_pkg::X_W-1:0]     x_q, x_d;
  logic [st13_pkg::Y_W-1:0]     y_q, y_d;
  logic [st13_pkg::Z_W-1:0]     z_q, z_d;
  logic [st13_pkg::OCNT_W-1:0]  out_cnt_q, out_cnt_d;
  st13_pkg::meta_t              meta_q, meta_d;
  st13_pkg::tap_t [st13_pkg::NUM_PLANES-1:0] taps;
  logic [st13_pkg::DATA_W-1:0]  link_mid, link_lo;
  st13_pkg::res_t               res;
  oent_t                        oq_q [st13_pkg::OUT_DEPTH];
  logic [st13_pkg::OPTR_W-1:0]  wr_ptr_q, rd_ptr_q;

  assign accept   = in_valid_i & ~in_stall_o;
  assign vol_full = (in_cnt_q == st13_pkg::CNT_W'(st13_pkg::VOL_LEN));
  assign take_smp = accept & ~mode_i & ~vol_full;
  assign take_drn = accept & mode_i & vol_full;
  assign shift    = take_smp | take_drn;
  assign emit     = take_drn | (take_smp & (in_cnt_q >= st13_pkg::CNT_W'(st13_pkg::LAG)));

  assign x_max = (x_q == st13_pkg::X_W'(st13_pkg::SIZE_X - 1));
  assign y_max = (y_q == st13_pkg::Y_W'(st13_pkg::SIZE_Y - 1));
  assign z_max = (z_q == st13_pkg::Z_W'(st13_pkg::SIZE_Z - 1));
  assign last_w   = x_max & y_max & z_max;
  assign bypass_w = (x_q == '0) | x_max | (y_q == '0) | y_max | (z_q == '0) | z_max;

  // voxel position of the next result, y fastest
  always_comb begin
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    if (emit) begin
      if (!y_max) begin
        y_d = y_q + st13_pkg::Y_W'(1);
      end else begin
        y_d = '0;
        if (!x_max) begin
          x_d = x_q + st13_pkg::X_W'(1);
        end else begin
          x_d = '0;
          z_d = z_max ? '0 : z_q + st13_pkg::Z_W'(1);
        end
      end
    end
  end

  always_comb begin
    in_cnt_d = in_cnt_q;
    if (emit && last_w) begin
      in_cnt_d = '0;
    end else if (take_smp) begin
      in_cnt_d = in_cnt_q + st13_pkg::CNT_W'(1);
    end
  end

  assign meta_d.valid  = emit;
  assign meta_d.bypass = bypass_w;
  assign meta_d.last   = last_w;

  assign out_cnt_d = out_cnt_q + st13_pkg::OCNT_W'(emit) - st13_pkg::OCNT_W'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_cnt_q  <= '0;
      x_q       <= '0;
      y_q       <= '0;
      z_q       <= '0;
      out_cnt_q <= '0;
      meta_q    <= '0;
    end else begin
      in_cnt_q  <= in_cnt_d;
      x_q       <= x_d;
      y_q       <= y_d;
      z_q       <= z_d;
      out_cnt_q <= out_cnt_d;
      meta_q    <= meta_d;
    end
  end

  // stall only on results not yet taken, so the queue can never overflow
  assign in_stall_o = (out_cnt_q == st13_pkg::OCNT_W'(st13_pkg::OUT_DEPTH));

  // plane cells: z+1, z, z-1
  st13_cell u_cell_hi (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (shift),
    .in_i    (sample_i),
    .taps_o  (taps[0]),
    .nxt_o   (link_mid)
  );

  st13_cell u_cell_mid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (shift),
    .in_i    (link_mid),
    .taps_o  (taps[1]),
    .nxt_o   (link_lo)
  );

  st13_cell u_cell_lo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (shift),
    .in_i    (link_lo),
    .taps_o  (taps[2]),
    .nxt_o   ()
  );

  st13_calc u_calc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .meta_i (meta_q),
    .taps_i (taps),
    .res_o  (res)
  );

  // output queue
  assign out_valid_o = (wr_ptr_q != rd_ptr_q);
  assign pop         = out_valid_o & ~out_stall_i;
  assign value_o     = oq_q[rd_ptr_q[st13_pkg::OUT_AW-1:0]].value;
  assign last_o      = oq_q[rd_ptr_q[st13_pkg::OUT_AW-1:0]].last;

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      oq_q[wr_ptr_q[st13_pkg::OUT_AW-1:0]] <= '{last: res.last, value: res.value};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      if (res.valid) begin
        wr_ptr_q <= wr_ptr_q + st13_pkg::OPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + st13_pkg::OPTR_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_out_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_cnt_q <= st13_pkg::OCNT_W'(st13_pkg::OUT_DEPTH))
    else $error("outstanding result count above queue depth");

  a_queue_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> ((wr_ptr_q - rd_ptr_q) != st13_pkg::OPTR_W'(st13_pkg::OUT_DEPTH)))
    else $error("result written into a full output queue");

  a_out_has_credit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_cnt_q != '0))
    else $error("queued result without an outstanding count");

  a_in_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_cnt_q <= st13_pkg::CNT_W'(st13_pkg::VOL_LEN))
    else $error("sample count beyond volume size");
`endif

endmodule

### tb/sv/stencil_3d_13pt_filter_unit_test.sv
// self-checking testbench for the 13-point stencil filter: streams volume samples,
// predicts every filtered voxel and compares it with what the block returns
// depends on st13_pkg and stencil_3d_13pt_filter_unit
module stencil_3d_13pt_filter_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RING_DEPTH  = 2 * st13_pkg::LAG + 1;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned SETTLE      = 40;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned MAX_REPORTS = 10;

  typedef enum logic {
    MODE_SAMPLE = 1'b0,
    MODE_DRAIN  = 1'b1
  } word_kind_e;

  typedef struct {
    word_kind_e                  kind;
    logic [st13_pkg::DATA_W-1:0] sample;
  } stencil_word_t;

  typedef struct {
    logic [st13_pkg::DATA_W-1:0] value;
    logic                        last;
  } voxel_result_t;

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        in_valid_i  = 1'b0;
  logic                        mode_i      = MODE_SAMPLE;
  logic [st13_pkg::DATA_W-1:0] sample_i    = '0;
  logic                        out_stall_i = 1'b0;
  logic                        in_stall_o;
  logic                        out_valid_o;
  logic [st13_pkg::DATA_W-1:0] value_o;
  logic                        last_o;

  stencil_word_t word_q[$];
  voxel_result_t voxel_due[$];

  // predictor state
  logic signed [st13_pkg::DATA_W-1:0] plane_ring[RING_DEPTH] = '{default: '0};
  int unsigned samples_taken = 0;
  int unsigned voxels_sent   = 0;

  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;
  int unsigned gap_left    = 0;
  int unsigned stall_left  = 0;
  int unsigned hold_left   = 0;
  int unsigned hold_asked  = 0;
  int unsigned hold_done   = 0;
  bit          quiet       = 1'b0;

  stencil_3d_13pt_filter_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .mode_i     (mode_i),
    .sample_i   (sample_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .value_o    (value_o),
    .last_o     (last_o)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL stencil_3d_13pt_filter_unit");
      $finish;
    end
  end

  function automatic longint ring_tap(int unsigned idx);
    return longint'(plane_ring[idx % RING_DEPTH]);
  endfunction

  // filtered value of the next voxel in raster order, counters advance
  task automatic emit_voxel();
    int unsigned   n;
    int unsigned   y;
    int unsigned   x;
    int unsigned   z;
    int unsigned   b;
    longint        acc;
    longint        quo;
    voxel_result_t res;
    n   = voxels_sent;
    y   = n % st13_pkg::ROW_LEN;
    x   = (n / st13_pkg::ROW_LEN) % st13_pkg::SIZE_X;
    z   = n / st13_pkg::PLANE_LEN;
    quo = ring_tap(n);
    if (x != 0 && x != st13_pkg::SIZE_X - 1 && y != 0 && y != st13_pkg::SIZE_Y - 1 &&
        z != 0 && z != st13_pkg::SIZE_Z - 1) begin
      acc = 12 * ring_tap(n);
      for (int p = 0; p < 3; p++) begin
        b   = n + p * st13_pkg::PLANE_LEN - st13_pkg::PLANE_LEN;
        acc = acc + ring_tap(b + 1) + ring_tap(b - 1)
              + ring_tap(b + st13_pkg::ROW_LEN + 1) + ring_tap(b - st13_pkg::ROW_LEN - 1);
      end
      // round toward minus infinity
      quo = acc / 13;
      if (acc % 13 != 0 && acc < 0) quo = quo - 1;
    end
    res.value = quo[st13_pkg::DATA_W-1:0];
    res.last  = (n == st13_pkg::VOL_LEN - 1);
    voxel_due.push_back(res);
    voxels_sent++;
    if (voxels_sent >= st13_pkg::VOL_LEN) begin
      voxels_sent   = 0;
      samples_taken = 0;
    end
  endtask

  task automatic stencil_accept(input logic kind, input logic [st13_pkg::DATA_W-1:0] word);
    if (kind == MODE_SAMPLE) begin
      if (samples_taken < st13_pkg::VOL_LEN) begin
        plane_ring[samples_taken % RING_DEPTH] = word;
        samples_taken++;
        if (samples_taken > st13_pkg::LAG) emit_voxel();
      end
    end else if (samples_taken >= st13_pkg::VOL_LEN && voxels_sent < st13_pkg::VOL_LEN) begin
      emit_voxel();
    end
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      mode_i     <= MODE_SAMPLE;
      sample_i   <= '0;
      gap_left   <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) stencil_accept(mode_i, sample_i);
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left   <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
          gap_left   <= $urandom_range(0, 3);
          in_valid_i <= 1'b0;
        end else if (word_q.size() > 0) begin
          in_valid_i <= 1'b1;
          mode_i     <= word_q[0].kind;
          sample_i   <= word_q[0].sample;
          void'(word_q.pop_front());
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with a long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
      hold_left   <= 0;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (hold_asked != hold_done) begin
      hold_done   <= hold_done + 1;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left  <= $urandom_range(0, 3);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    voxel_result_t due;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (voxel_due.size() == 0) begin
        fail_count <= fail_count + 1;
        if (fail_count < MAX_REPORTS)
          $display("unexpected word: value %h last %b", value_o, last_o);
      end else begin
        due = voxel_due.pop_front();
        if (value_o !== due.value || last_o !== due.last) begin
          fail_count <= fail_count + 1;
          if (fail_count < MAX_REPORTS)
            $display("mismatch: value %h last %b, expected value %h last %b",
                     value_o, last_o, due.value, due.last);
        end
      end
    end
  end

  // rows along x come in blocks of three sharing one kind of content, so interior
  // voxels also see taps that are all at the positive or negative extreme
  function automatic logic [st13_pkg::DATA_W-1:0] voxel_word(int unsigned vol,
                                                             int unsigned n);
    logic [st13_pkg::DATA_W-1:0] w;
    case ((n / st13_pkg::ROW_LEN % st13_pkg::SIZE_X / 3 + vol) % 5)
      0: w = $urandom;
      1: w = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2: w = st13_pkg::DATA_W'(int'($urandom_range(0, 40)) - 20);
      3: w = 32'h7FFF_FFFF;
      default: w = 32'h8000_0000;
    endcase
    return w;
  endfunction

  task automatic push_word(word_kind_e kind, logic [st13_pkg::DATA_W-1:0] sample);
    stencil_word_t w;
    w.kind   = kind;
    w.sample = sample;
    word_q.push_back(w);
  endtask

  // early drain words mixed in when noisy, they must do nothing
  task automatic queue_volume(int unsigned vol, int unsigned first, int unsigned count,
                              bit noisy);
    for (int unsigned n = first; n < first + count; n++) begin
      if (noisy && $urandom_range(0, 31) == 0) push_word(MODE_DRAIN, $urandom);
      push_word(MODE_SAMPLE, voxel_word(vol, n));
    end
  endtask

  task automatic wait_sender_idle();
    while (word_q.size() != 0 || in_valid_i) @(posedge clk_i);
  endtask

  task automatic wait_results_done();
    while (voxel_due.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [st13_pkg::DATA_W-1:0] corner_words[10];
    corner_words = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
                     32'h0001_0000, 32'hFFFF_0000, 32'h0000_0001, 32'hAAAA_AAAA,
                     32'h5555_5555, 32'h8000_0001};

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_word(MODE_DRAIN, 32'hFFFF_FFFF);
    push_word(MODE_DRAIN, 32'h0000_0000);
    foreach (corner_words[i]) push_word(MODE_SAMPLE, corner_words[i]);

    queue_volume(0, 10, 800, 1'b1);
    wait_sender_idle();
    // output side holds off while words keep coming, so the block backs up
    hold_asked = hold_asked + 1;
    queue_volume(0, 810, 500, 1'b1);

    // sender stays quiet until every result is back
    wait_sender_idle();
    wait_results_done();

    quiet = 1'b1;
    queue_volume(0, 1310, 500, 1'b0);

    wait_sender_idle();
    wait_results_done();
    repeat (SETTLE) @(posedge clk_i);

    if (fail_count == 0 && voxel_due.size() == 0) begin
      $display("PASS stencil_3d_13pt_filter_unit");
    end else begin
      $display("FAIL stencil_3d_13pt_filter_unit");
    end
    $finish;
  end

endmodule

### stencil_3d_13pt_filter_unit.f
design/st13_pkg.sv
design/st13_dly_ram.sv
design/st13_cell.sv
design/st13_calc.sv
design/stencil_3d_13pt_filter_unit.sv
tb/sv/stencil_3d_13pt_filter_unit_test.sv
